@@ sv/lfs_pkg.sv @@
// Shared types, codes and helper functions for the line follow steering unit.
`timescale 1ns / 1ps

package lfs_pkg;

  // Field widths
  localparam int unsigned BaseW   = 7;
  localparam int unsigned PatW    = 8;
  localparam int unsigned SpeedW  = 9;
  localparam int unsigned DriveW  = 8;
  localparam int unsigned RunW    = 10;
  localparam int unsigned CfgIdxW = 1;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_START  = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_SPEED = 1'd0,
    REG_STOP_WHITE = 1'd1
  } reg_idx_e;

  // Remembered extreme side of the line
  typedef enum logic [1:0] {
    SIDE_CENTER = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_LEFT   = 2'd2
  } side_e;

  // Stop reasons
  typedef enum logic [1:0] {
    STOP_RUN     = 2'd0,
    STOP_LOST    = 2'd1,
    STOP_TIMEOUT = 2'd2
  } stop_e;

  // Steering classes decoded from the sensor pattern
  typedef enum logic [3:0] {
    TURN_NONE,
    TURN_STRAIGHT,
    TURN_R1,
    TURN_R2,
    TURN_R3,
    TURN_R4,
    TURN_L1,
    TURN_L2,
    TURN_L3,
    TURN_L4
  } turn_e;

  localparam logic [PatW-1:0] PatAllBlack = 8'h00;
  localparam logic [PatW-1:0] PatAllWhite = 8'hFF;

  localparam logic signed [SpeedW-1:0] DrvMax = 9'sd100;
  localparam logic signed [SpeedW-1:0] DrvMin = 9'sd5;

  typedef struct packed {
    logic [BaseW-1:0] base_speed;
    logic             stop_white;
  } cfg_t;

  typedef struct packed {
    logic                     tracking;
    side_e                    side;
    logic [RunW-1:0]          white_run;
    logic signed [SpeedW-1:0] left_speed;
    logic signed [SpeedW-1:0] right_speed;
    stop_e                    last_stop;
  } state_t;

  typedef struct packed {
    logic                     motor_send;
    logic signed [DriveW-1:0] left_drive;
    logic signed [DriveW-1:0] right_drive;
    stop_e                    stop_code;
    logic                     tracking;
  } result_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] left_off;
    logic signed [SpeedW-1:0] right_off;
  } offset_t;

  // Map a sensor pattern to its steering class
  function automatic turn_e pattern_turn(logic [PatW-1:0] pat);
    turn_e t;
    unique case (pat) inside
      8'hE7, 8'hF7, 8'hEF: t = TURN_STRAIGHT;
      8'hF3, 8'hFB:        t = TURN_R1;
      8'hF9, 8'hFD:        t = TURN_R2;
      8'hFC:               t = TURN_R3;
      8'hFE:               t = TURN_R4;
      8'hCF:               t = TURN_L1;
      8'h9F, 8'hDF:        t = TURN_L2;
      8'h3F, 8'hBF:        t = TURN_L3;
      8'h7F:               t = TURN_L4;
      default:             t = TURN_NONE;
    endcase
    return t;
  endfunction

  // Wheel offsets relative to base speed for each class
  function automatic offset_t turn_offset(turn_e t);
    offset_t o;
    case (t)
      TURN_R1: o = '{left_off: 9'sd30,  right_off: -9'sd30};
      TURN_R2: o = '{left_off: 9'sd40,  right_off: -9'sd60};
      TURN_R3: o = '{left_off: 9'sd50,  right_off: -9'sd90};
      TURN_R4: o = '{left_off: 9'sd60,  right_off: -9'sd120};
      TURN_L1: o = '{left_off: -9'sd30, right_off: 9'sd30};
      TURN_L2: o = '{left_off: -9'sd60, right_off: 9'sd40};
      TURN_L3: o = '{left_off: -9'sd90, right_off: 9'sd50};
      TURN_L4: o = '{left_off: -9'sd120, right_off: 9'sd60};
      default: o = '{left_off: 9'sd0,   right_off: 9'sd0};
    endcase
    return o;
  endfunction

  // Clamp a speed to magnitude 5..100, keeping its sign (zero counts positive)
  function automatic logic signed [DriveW-1:0] clamp_drive(logic signed [SpeedW-1:0] v);
    logic signed [SpeedW-1:0] r;
    if (!v[SpeedW-1]) begin
      if (v > DrvMax) r = DrvMax;
      else if (v < DrvMin) r = DrvMin;
      else r = v;
    end else begin
      if (v < -DrvMax) r = -DrvMax;
      else if (v > -DrvMin) r = -DrvMin;
      else r = v;
    end
    return r[DriveW-1:0];
  endfunction

endpackage

@@ sv/line_follow_steering_unit.sv @@
// Top level of the line follow steering unit: input stage, state and result register.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per beat: a kind
//   (sample, start, clear) and an 8-bit sensor pattern. Every item yields
//   exactly one result beat on the output channel (out_valid_o / out_stall_i):
//   motor_send, left/right drive, stop code and tracking flag.
//   Path: an accepted beat sits in the input register and moves on to the
//   result register once that register is free or drained.
//   Throughput: one item per cycle while out_stall_i does not hold a waiting
//   result; the steering state is updated by a single compare-and-add step
//   between the input and result registers.
//   Stalls: when out_stall_i holds a waiting result, the input register keeps
//   its item and in_stall_o rises only if that register is full as well.
//   Configuration: cfg_valid_i / cfg_ready_o write base speed (index 0) or the
//   stop-on-all-white flag (index 1); ready is always high. Write only while
//   no item is in flight.
//   Reset: tracking off, side centered, white run and speeds zero, base speed
//   50, stop-on-white off; both pipeline registers empty.
module line_follow_steering_unit #(
  parameter int WHITE_LIMIT = 1000
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lfs_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [lfs_pkg::BaseW-1:0]           cfg_data_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          kind_i,
  input  logic [lfs_pkg::PatW-1:0]            sensor_pattern_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                motor_send_o,
  output logic signed [lfs_pkg::DriveW-1:0]   left_drive_o,
  output logic signed [lfs_pkg::DriveW-1:0]   right_drive_o,
  output logic [1:0]                          stop_code_o,
  output logic                                tracking_o
);

  lfs_pkg::cfg_t                   cfg;
  lfs_pkg::state_t                 st_q, st_d;
  lfs_pkg::result_t                res_q, res_d;
  logic                            in_vld_q;
  logic [1:0]                      kind_q;
  logic [lfs_pkg::PatW-1:0]        pat_q;
  logic                            out_vld_q;
  logic                            adv;
  logic                            in_take;

  assign cfg_ready_o = 1'b1;

  lfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: stage advances when the result register is free or drained
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q <= kind_i;
      pat_q  <= sensor_pattern_i;
    end
  end

  lfs_steer #(
    .WHITE_LIMIT (WHITE_LIMIT)
  ) u_steer (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .kind_i (kind_q),
    .pat_i  (pat_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // Steering state, committed as each item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.tracking    <= 1'b0;
      st_q.side        <= lfs_pkg::SIDE_CENTER;
      st_q.white_run   <= '0;
      st_q.left_speed  <= '0;
      st_q.right_speed <= '0;
      st_q.last_stop   <= lfs_pkg::STOP_RUN;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end

  assign out_valid_o   = out_vld_q;
  assign motor_send_o  = res_q.motor_send;
  assign left_drive_o  = res_q.left_drive;
  assign right_drive_o = res_q.right_drive;
  assign stop_code_o   = res_q.stop_code;
  assign tracking_o    = res_q.tracking;

`ifndef ASSERT_OFF
  // While tracking, the stop code reads running
  a_track_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tracking_o |-> stop_code_o == lfs_pkg::STOP_RUN)
    else $error("tracking result with nonzero stop code");

  // A command that stops the car carries zero drives
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tracking_o |-> left_drive_o == '0 && right_drive_o == '0)
    else $error("drive issued while not tracking");

  // A running command never carries a zero drive
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motor_send_o && tracking_o |-> left_drive_o != '0 && right_drive_o != '0)
    else $error("running command with zero drive");

  // White run counter never passes one beyond the limit
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.white_run <= lfs_pkg::RunW'(WHITE_LIMIT + 1))
    else $error("white run counter out of range");

  // Stall only when the input register holds an item that cannot advance
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled without a blocked item");
`endif

endmodule

@@ sv/lfs_cfg_regs.sv @@
// Configuration registers of the line follow steering unit.
`timescale 1ns / 1ps

module lfs_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [lfs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [lfs_pkg::BaseW-1:0]        cfg_data_i,
  output lfs_pkg::cfg_t                    cfg_o
);

  lfs_pkg::cfg_t cfg_q, cfg_d;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lfs_pkg::REG_BASE_SPEED: cfg_d.base_speed = cfg_data_i;
        lfs_pkg::REG_STOP_WHITE: cfg_d.stop_white = cfg_data_i[0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_speed <= lfs_pkg::BaseW'(50);
      cfg_q.stop_white <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/lfs_steer.sv @@
// Next-state and result logic for one item of the steering unit.
`timescale 1ns / 1ps

module lfs_steer #(
  parameter int WHITE_LIMIT = 1000
) (
  input  lfs_pkg::cfg_t                cfg_i,
  input  lfs_pkg::state_t              st_i,
  input  logic [1:0]                   kind_i,
  input  logic [lfs_pkg::PatW-1:0]     pat_i,
  output lfs_pkg::state_t              st_o,
  output lfs_pkg::result_t             res_o
);

  lfs_pkg::turn_e                      turn;
  lfs_pkg::offset_t                    off;
  logic signed [lfs_pkg::SpeedW-1:0]   base_s;
  logic                                turn_ok;
  logic                                is_sample;

  assign turn   = lfs_pkg::pattern_turn(pat_i);
  assign off    = lfs_pkg::turn_offset(turn);
  assign base_s = signed'({2'b00, cfg_i.base_speed});

  // Right turns are blocked when far left is remembered, and vice versa
  always_comb begin
    case (turn) inside
      lfs_pkg::TURN_STRAIGHT: turn_ok = 1'b1;
      lfs_pkg::TURN_R1, lfs_pkg::TURN_R2, lfs_pkg::TURN_R3, lfs_pkg::TURN_R4:
        turn_ok = (st_i.side != lfs_pkg::SIDE_LEFT);
      lfs_pkg::TURN_L1, lfs_pkg::TURN_L2, lfs_pkg::TURN_L3, lfs_pkg::TURN_L4:
        turn_ok = (st_i.side != lfs_pkg::SIDE_RIGHT);
      default: turn_ok = 1'b0;
    endcase
  end

  // State update per item kind
  always_comb begin
    st_o      = st_i;
    is_sample = 1'b0;
    unique case (kind_i)
      lfs_pkg::KIND_START: begin
        st_o.tracking  = 1'b1;
        st_o.last_stop = lfs_pkg::STOP_RUN;
      end
      lfs_pkg::KIND_CLEAR: begin
        st_o.tracking  = 1'b0;
        st_o.last_stop = lfs_pkg::STOP_RUN;
      end
      lfs_pkg::KIND_SAMPLE: begin
        is_sample = st_i.tracking;
        if (st_i.tracking) begin
          if (pat_i == lfs_pkg::PatAllBlack) begin
            st_o.tracking  = 1'b0;
            st_o.last_stop = lfs_pkg::STOP_LOST;
          end else begin
            st_o.last_stop = lfs_pkg::STOP_RUN;
            // speed and side from the pattern
            if (turn_ok) begin
              st_o.left_speed  = base_s + off.left_off;
              st_o.right_speed = base_s + off.right_off;
              case (turn)
                lfs_pkg::TURN_STRAIGHT: st_o.side = st_i.side;
                lfs_pkg::TURN_R4:       st_o.side = lfs_pkg::SIDE_RIGHT;
                lfs_pkg::TURN_L4:       st_o.side = lfs_pkg::SIDE_LEFT;
                default:                st_o.side = lfs_pkg::SIDE_CENTER;
              endcase
            end
            // all-white handling and run counter
            if (pat_i == lfs_pkg::PatAllWhite) begin
              if (cfg_i.stop_white) begin
                st_o.tracking  = 1'b0;
                st_o.last_stop = lfs_pkg::STOP_LOST;
              end
              if (st_i.white_run > lfs_pkg::RunW'(WHITE_LIMIT)) begin
                st_o.white_run = '0;
                st_o.tracking  = 1'b0;
                if (st_i.side == lfs_pkg::SIDE_CENTER) st_o.last_stop = lfs_pkg::STOP_TIMEOUT;
              end else begin
                st_o.white_run = st_i.white_run + lfs_pkg::RunW'(1);
              end
            end else begin
              st_o.white_run = '0;
            end
          end
        end
      end
      default: st_o = st_i;
    endcase
  end

  // Result beat
  always_comb begin
    res_o.motor_send  = is_sample;
    res_o.left_drive  = '0;
    res_o.right_drive = '0;
    if (is_sample && st_o.tracking) begin
      res_o.left_drive  = lfs_pkg::clamp_drive(st_o.left_speed);
      res_o.right_drive = lfs_pkg::clamp_drive(st_o.right_speed);
    end
    res_o.stop_code = st_o.last_stop;
    res_o.tracking  = st_o.tracking;
  end

endmodule
